FILE: sv/assert_macros.svh
// Assertion macros for the RTL of the plasma pixel generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, ck, rs, cond) \
  label: assert property (@(posedge ck) disable iff (rs) (cond)) \
    else $error("assertion failed: condition does not hold");
// Check that a condition at one edge brings a consequence at the next edge.
`define ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed: consequence missing one cycle later");
`else
`define ASSERT_ALWAYS(label, ck, rs, cond)
`define ASSERT_NEXT(label, ck, rs, ante, cons)
`endif
`endif

FILE: sv/ppg_pkg.sv
// Package of the plasma pixel generator: payload types, register codes, constants.
package ppg_pkg;

  localparam int COORD_W    = 9;
  localparam int COLOUR_W   = 8;
  localparam int WAVES      = 5;
  localparam int X_WAVES    = 3;
  localparam int LANES      = WAVES + 1;
  localparam int FIELD_W    = 12;
  localparam int AMP_W      = 8;
  localparam int AMPS_W     = WAVES * AMP_W;
  localparam int FIELDS_W   = WAVES * FIELD_W;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_ADDR_LSB = 3;

  // Sine polynomial, Q1.14.
  localparam int SINE_FRAC = 14;
  localparam int SINE_ONE  = 16384;
  localparam int POLY_A    = 10597;
  localparam int POLY_B    = 1245;
  localparam int POLY_C    = 25736;
  localparam int T_W       = 16;
  localparam int X_W       = 15;
  localparam int R1_W      = 14;
  localparam int R2_W      = 15;
  localparam int SINE_W    = 16;
  localparam int PROD_W    = 24;
  localparam int SUM_W     = 26;

  // Phase scale of 1.3 applied to the second cosine.
  localparam int SCALE_NUM = 13;
  localparam int SCALE_DEN = 10;

  typedef enum logic [1:0] {
    REG_AMPLITUDES,
    REG_SPATIAL_STEPS,
    REG_FRAME_SPEEDS,
    REG_START_PHASES
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               restart;
    logic               frame_end;
  } coord_t;

  typedef struct packed {
    logic [COLOUR_W-1:0] colour;
    logic                frame_last;
  } result_t;

  // Truncate a Q14 wave sum toward zero and keep the low colour bits.
  function automatic logic [COLOUR_W-1:0] trunc_low(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-1:0]    mag;
    logic [COLOUR_W-1:0] m;
    mag = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
    m   = mag[SINE_FRAC +: COLOUR_W];
    return v[SUM_W-1] ? COLOUR_W'(-m) : m;
  endfunction

endpackage

FILE: sv/plasma_pixel_generator.sv
// Top level of the plasma pixel generator: eleven-stage sine plasma colour pipeline.
//
// Usage: one coord transaction (column, row, restart, frame_end) goes in, one
// result transaction (colour, frame_last) comes out, in the same order.
// Both channels move a transaction at a rising edge where valid is high and
// stall is low. The colour adds two parts, each truncated to 8 bits: three column
// sines, and a row sine and two row cosines, each scaled by an 8-bit amplitude.
// A pipeline of eleven register stages runs from coord acceptance to result_valid;
// the sine is evaluated in place by a four-multiply polynomial chain per wave.
// Throughput: one transaction every cycle while result_stall is low.
// A result that waits under result_stall holds its stage; items behind it
// close up into empty stages, and coord_stall rises only once all eleven
// stages hold an item.
// The five frame phases update as each coord transaction is accepted:
// restart loads the start phases first, frame_end adds the frame speeds after.
// Configuration: APB port, 64-bit data, register i at byte address 8*i; the user
// writes only with the pipeline empty, unchecked by the block; pready is always high.
// Reset (rst, synchronous) empties the pipeline and clears the frame phases
// and all configuration registers.
`include "assert_macros.svh"

module plasma_pixel_generator #(
  parameter int SINE_ENTRIES = 1024,
  parameter int PHASE_BITS   = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           coord_valid,
  output logic                           coord_stall,
  input  ppg_pkg::coord_t                coord,
  output logic                           result_valid,
  input  logic                           result_stall,
  output ppg_pkg::result_t               result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ppg_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ppg_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ppg_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import ppg_pkg::*;

  localparam int PB    = PHASE_BITS;
  localparam int IDX_W = $clog2(SINE_ENTRIES);
  localparam int ENT_W = $clog2(SINE_ENTRIES + 1);
  localparam int FW    = (PB < FIELD_W) ? PB : FIELD_W;
  localparam logic [PB-1:0] QUARTER = PB'(1) << (PB - 2);

  // Phase to table index: (phase * SINE_ENTRIES) >> PB.
  localparam int IDX_PW = PB + ENT_W;

  // Table index to turn fraction: index * 2^16 / SINE_ENTRIES, by reciprocal.
  localparam int     TDIV_K  = 2 * IDX_W + T_W;
  localparam longint TDIV_M  = ((longint'(1) << TDIV_K) + longint'(SINE_ENTRIES) - 1)
                               / longint'(SINE_ENTRIES);
  localparam int     TDIV_MW = $clog2(TDIV_M + 1);
  localparam int     TDIV_PW = IDX_W + TDIV_MW;
  localparam int     TDIV_SH = TDIV_K - T_W;

  // Phase times 1.3: phase * 13 / 10, by reciprocal.
  localparam int     D10_K  = PB + $clog2(SCALE_NUM) + $clog2(SCALE_DEN);
  localparam longint D10_M  = ((longint'(1) << D10_K) + SCALE_DEN - 1) / SCALE_DEN;
  localparam longint P13_M  = SCALE_NUM * D10_M;
  localparam int     P13_MW = $clog2(P13_M + 1);
  localparam int     P13_PW = PB + P13_MW;

  localparam int STEP_PW = PB + COORD_W;
  localparam int SQ_PW   = 2 * X_W;
  localparam int STAGES  = 11;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [AMPS_W-1:0]   amplitudes;
  logic [FIELDS_W-1:0] spatial_steps;
  logic [FIELDS_W-1:0] frame_speeds;
  logic [FIELDS_W-1:0] start_phases;
  cfg_reg_t            cfg_sel;
  logic                cfg_write;

  assign pready    = 1'b1;
  assign cfg_sel   = cfg_reg_t'(paddr[CFG_ADDR_W-1:CFG_ADDR_LSB]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitudes    <= '0;
      spatial_steps <= '0;
      frame_speeds  <= '0;
      start_phases  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        REG_AMPLITUDES:    amplitudes    <= pwdata[AMPS_W-1:0];
        REG_SPATIAL_STEPS: spatial_steps <= pwdata[FIELDS_W-1:0];
        REG_FRAME_SPEEDS:  frame_speeds  <= pwdata[FIELDS_W-1:0];
        REG_START_PHASES:  start_phases  <= pwdata[FIELDS_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_AMPLITUDES:    prdata = CFG_DATA_W'(amplitudes);
      REG_SPATIAL_STEPS: prdata = CFG_DATA_W'(spatial_steps);
      REG_FRAME_SPEEDS:  prdata = CFG_DATA_W'(frame_speeds);
      REG_START_PHASES:  prdata = CFG_DATA_W'(start_phases);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage handshake: a stage takes a new item when it is empty or its item
  // moves on in the same cycle, so bubbles close up under a stalled output.
  // ---------------------------------------------------------------------------
  logic [STAGES:1]   stage_valid;
  logic [STAGES:1]   stage_en;
  logic [STAGES-1:1] stage_last;
  logic              coord_acc;

  always_comb begin
    stage_en[STAGES] = !stage_valid[STAGES] || !result_stall;
    for (int k = STAGES - 1; k >= 1; k--) begin
      stage_en[k] = !stage_valid[k] || stage_en[k+1];
    end
  end

  assign coord_stall = !stage_en[1];
  assign coord_acc   = coord_valid && stage_en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_en[1]) begin
        stage_valid[1] <= coord_valid;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (stage_en[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  // Frame marker travels beside the data; the last stage keeps it in result.
  always_ff @(posedge clk) begin
    if (coord_acc) begin
      stage_last[1] <= coord.frame_end;
    end
    for (int k = 2; k < STAGES; k++) begin
      if (stage_en[k] && stage_valid[k-1]) begin
        stage_last[k] <= stage_last[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: frame phases and per-wave phases
  // ---------------------------------------------------------------------------
  logic [WAVES-1:0][PB-1:0]      frame_phases;
  logic [WAVES-1:0][PB-1:0]      fp_eff;
  logic [WAVES-1:0][PB-1:0]      fp_adv;
  logic [WAVES-1:0][STEP_PW-1:0] step_prod;
  logic [WAVES-1:0][PB-1:0]      s1_phase_next;
  logic [WAVES-1:0][PB-1:0]      s1_phase;

  always_comb begin
    for (int i = 0; i < WAVES; i++) begin
      // Load the start phases first on restart.
      fp_eff[i] = coord.restart ? PB'(start_phases[i*FIELD_W +: FW]) : frame_phases[i];
      fp_adv[i] = fp_eff[i] + PB'(frame_speeds[i*FIELD_W +: FW]);
      step_prod[i] = STEP_PW'((i < X_WAVES) ? coord.column : coord.row)
                   * STEP_PW'(spatial_steps[i*FIELD_W +: FW]);
      s1_phase_next[i] = fp_eff[i] + step_prod[i][PB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_phases <= '0;
    end else if (coord_acc) begin
      frame_phases <= coord.frame_end ? fp_adv : fp_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (coord_acc) begin
      s1_phase <= s1_phase_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: cosine phases, including the 1.3 times scaled one
  // ---------------------------------------------------------------------------
  logic [P13_PW-1:0]        p13_prod;
  logic [LANES-1:0][PB-1:0] s2_phase_next;
  logic [LANES-1:0][PB-1:0] s2_phase;

  always_comb begin
    p13_prod = P13_PW'(s1_phase[WAVES-1]) * P13_PW'(P13_M);
    for (int i = 0; i < WAVES - 1; i++) begin
      s2_phase_next[i] = s1_phase[i];
    end
    s2_phase_next[WAVES-1] = s1_phase[WAVES-1] + QUARTER;
    s2_phase_next[WAVES]   = p13_prod[D10_K +: PB] + QUARTER;
  end

  always_ff @(posedge clk) begin
    if (stage_en[2] && stage_valid[1]) begin
      s2_phase <= s2_phase_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 3 and 4: table index, then turn fraction of that index
  // ---------------------------------------------------------------------------
  logic [LANES-1:0][IDX_PW-1:0]  idx_prod;
  logic [LANES-1:0][IDX_W-1:0]   s3_idx_next;
  logic [LANES-1:0][IDX_W-1:0]   s3_idx;
  logic [LANES-1:0][TDIV_PW-1:0] turn_prod;
  logic [LANES-1:0][T_W-1:0]     s4_turn_next;
  logic [LANES-1:0][T_W-1:0]     s4_turn;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      idx_prod[l]     = IDX_PW'(s2_phase[l]) * IDX_PW'(SINE_ENTRIES);
      s3_idx_next[l]  = idx_prod[l][PB +: IDX_W];
      turn_prod[l]    = TDIV_PW'(s3_idx[l]) * TDIV_PW'(TDIV_M);
      s4_turn_next[l] = turn_prod[l][TDIV_SH +: T_W];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[3] && stage_valid[2]) begin
      s3_idx <= s3_idx_next;
    end
    if (stage_en[4] && stage_valid[3]) begin
      s4_turn <= s4_turn_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 5 to 8: sine polynomial, one multiply per stage
  // ---------------------------------------------------------------------------
  logic [LANES-1:0][X_W-1:0]   x_fold;
  logic [LANES-1:0][SQ_PW-1:0] sq_prod;
  logic [LANES-1:0][SQ_PW-1:0] m1_prod;
  logic [LANES-1:0][SQ_PW-1:0] m2_prod;
  logic [LANES-1:0][SQ_PW-1:0] m3_prod;
  logic [LANES-1:0][X_W-1:0]   sine_mag;
  logic [LANES-1:0][X_W-1:0]   sine_lim;

  logic [LANES-1:0][X_W-1:0]   s5_x_next, s5_sq_next;
  logic [LANES-1:0]            s5_neg_next;
  logic [LANES-1:0][R1_W-1:0]  s6_r1_next;
  logic [LANES-1:0][R2_W-1:0]  s7_r2_next;
  logic signed [SINE_W-1:0]    s8_sine_next [LANES];

  logic [LANES-1:0][X_W-1:0]   s5_x, s5_sq, s6_x, s6_sq, s7_x;
  logic [LANES-1:0]            s5_neg, s6_neg, s7_neg;
  logic [LANES-1:0][R1_W-1:0]  s6_r1;
  logic [LANES-1:0][R2_W-1:0]  s7_r2;
  logic signed [SINE_W-1:0]    s8_sine [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      // Fold odd quadrants back onto the rising quarter wave.
      x_fold[l] = s4_turn[l][SINE_FRAC]
                ? X_W'(SINE_ONE) - X_W'(s4_turn[l][SINE_FRAC-1:0])
                : X_W'(s4_turn[l][SINE_FRAC-1:0]);
      sq_prod[l]     = SQ_PW'(x_fold[l]) * SQ_PW'(x_fold[l]);
      s5_x_next[l]   = x_fold[l];
      s5_sq_next[l]  = sq_prod[l][SINE_FRAC +: X_W];
      s5_neg_next[l] = s4_turn[l][SINE_FRAC+1];

      m1_prod[l]    = SQ_PW'(s5_sq[l]) * SQ_PW'(POLY_B);
      s6_r1_next[l] = R1_W'(POLY_A) - R1_W'(m1_prod[l] >> SINE_FRAC);

      m2_prod[l]    = SQ_PW'(s6_sq[l]) * SQ_PW'(s6_r1[l]);
      s7_r2_next[l] = R2_W'(POLY_C) - R2_W'(m2_prod[l] >> SINE_FRAC);

      m3_prod[l]  = SQ_PW'(s7_x[l]) * SQ_PW'(s7_r2[l]);
      sine_mag[l] = m3_prod[l][SINE_FRAC +: X_W];
      // Limit to one; negate in the lower half turn.
      sine_lim[l] = (sine_mag[l] > X_W'(SINE_ONE)) ? X_W'(SINE_ONE) : sine_mag[l];
      s8_sine_next[l] = s7_neg[l] ? -$signed(SINE_W'(sine_lim[l]))
                                  : $signed(SINE_W'(sine_lim[l]));
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[5] && stage_valid[4]) begin
      s5_x   <= s5_x_next;
      s5_sq  <= s5_sq_next;
      s5_neg <= s5_neg_next;
    end
    if (stage_en[6] && stage_valid[5]) begin
      s6_x   <= s5_x;
      s6_sq  <= s5_sq;
      s6_neg <= s5_neg;
      s6_r1  <= s6_r1_next;
    end
    if (stage_en[7] && stage_valid[6]) begin
      s7_x   <= s6_x;
      s7_neg <= s6_neg;
      s7_r2  <= s7_r2_next;
    end
    if (stage_en[8] && stage_valid[7]) begin
      s8_sine <= s8_sine_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 9 to 11: amplitude scaling, wave sums, colour
  // ---------------------------------------------------------------------------
  logic [AMP_W-1:0]         amp_sel [LANES];
  logic signed [PROD_W-1:0] s9_prod_next [LANES];
  logic signed [PROD_W-1:0] s9_prod [LANES];
  logic signed [SUM_W-1:0]  s10_xs_next, s10_ys_next;
  logic signed [SUM_W-1:0]  s10_xs, s10_ys;
  result_t                  s11_result_next;
  result_t                  s11_result;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      // Both row cosines share the fifth amplitude.
      amp_sel[l] = amplitudes[((l < WAVES) ? l : WAVES - 1)*AMP_W +: AMP_W];
      s9_prod_next[l] = PROD_W'($signed({1'b0, amp_sel[l]})) * PROD_W'(s8_sine[l]);
    end
    s10_xs_next = SUM_W'(s9_prod[0]) + SUM_W'(s9_prod[1]) + SUM_W'(s9_prod[2]);
    s10_ys_next = SUM_W'(s9_prod[3]) + SUM_W'(s9_prod[4]) + SUM_W'(s9_prod[5]);
    s11_result_next.colour     = trunc_low(s10_xs) + trunc_low(s10_ys);
    s11_result_next.frame_last = stage_last[STAGES-1];
  end

  always_ff @(posedge clk) begin
    if (stage_en[9] && stage_valid[8]) begin
      s9_prod <= s9_prod_next;
    end
    if (stage_en[10] && stage_valid[9]) begin
      s10_xs <= s10_xs_next;
      s10_ys <= s10_ys_next;
    end
    if (stage_en[11] && stage_valid[10]) begin
      s11_result <= s11_result_next;
    end
  end

  assign result_valid = stage_valid[STAGES];
  assign result       = s11_result;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // Hold off the input only with every stage occupied.
  `ASSERT_ALWAYS(a_stall_only_when_full, clk, rst, !coord_stall || (&stage_valid))
  // Keep the frame phases unless a restart or frame end transaction arrives.
  `ASSERT_NEXT(a_phases_hold, clk, rst, !coord_acc || (!coord.restart && !coord.frame_end), $stable(frame_phases))
  // Keep an item in the first stage while the second cannot take it.
  `ASSERT_NEXT(a_stage_keeps_item, clk, rst, stage_valid[1] && !stage_en[2], stage_valid[1])

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the plasma pixel generator: directed and random coord traffic.
`timescale 1ns / 100ps

module testbench;
  import ppg_pkg::*;

  // Match the block's default parameters.
  localparam int SINE_LEN   = 1024;
  localparam int PHASE_W    = 12;
  localparam int PHASE_MASK = (1 << PHASE_W) - 1;
  localparam int QUARTER    = 1 << (PHASE_W - 2);
  localparam int Q14        = 14;
  // Phase multiplier of the second row cosine is 13/10.
  localparam int MUL_NUM    = 13;
  localparam int MUL_DEN    = 10;
  localparam int PIPE_DEPTH = 11;
  localparam int REPORT_CAP = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  coord_valid  = 1'b0;
  logic                  coord_stall;
  coord_t                coord        = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Mirror of the configuration registers and of the running frame phases.
  logic [AMPS_W-1:0]   amp_cfg   = '0;
  logic [FIELDS_W-1:0] step_cfg  = '0;
  logic [FIELDS_W-1:0] speed_cfg = '0;
  logic [FIELDS_W-1:0] start_cfg = '0;
  int unsigned         frame_phase [WAVES];

  // Colours still owed by the block, oldest first.
  result_t pending_pixels [$];

  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int items_sent     = 0;
  int mismatch_count = 0;

  plasma_pixel_generator DUT (
    .clk          (clk),
    .rst          (rst),
    .coord_valid  (coord_valid),
    .coord_stall  (coord_stall),
    .coord        (coord),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Colour predictor
  // ---------------------------------------------------------------------------

  // Q1.14 sine table entry, built from the quadrant-folded polynomial.
  function automatic longint sine_entry(int unsigned k);
    longint unsigned t, x, x2, r, s;
    int unsigned     quad;
    t    = (64'(k) << 16) / SINE_LEN;
    quad = 32'((t >> Q14) & 64'd3);
    x    = t & 64'h3FFF;
    if (quad % 2 == 1) x = 64'd16384 - x;
    x2 = (x * x) >> Q14;
    r  = 64'd10597 - ((x2 * 64'd1245) >> Q14);
    r  = 64'd25736 - ((x2 * r) >> Q14);
    s  = (x * r) >> Q14;
    if (s > 64'd16384) s = 64'd16384;
    return (quad >= 2) ? -longint'(s) : longint'(s);
  endfunction

  // Sine at a phase given as a fraction of a turn.
  function automatic longint wave_level(int unsigned phase);
    int unsigned idx;
    idx = ((phase & PHASE_MASK) * SINE_LEN) >> PHASE_W;
    if (idx >= SINE_LEN) idx = SINE_LEN - 1;
    return sine_entry(idx);
  endfunction

  function automatic int unsigned phase_field(logic [FIELDS_W-1:0] packed_v, int i);
    return int'(packed_v[FIELD_W*i +: FIELD_W]) & PHASE_MASK;
  endfunction

  function automatic longint wave_amp(int i);
    return longint'(amp_cfg[AMP_W*i +: AMP_W]);
  endfunction

  // Drop the Q14 fraction, rounding toward zero, and keep eight bits.
  function automatic logic [COLOUR_W-1:0] toward_zero_byte(longint v);
    longint unsigned     mag;
    logic [COLOUR_W-1:0] lo;
    if (v < 0) begin
      mag = -v;
      lo  = COLOUR_W'(mag >> Q14);
      return COLOUR_W'(8'd0 - lo);
    end
    return COLOUR_W'(v >> Q14);
  endfunction

  function automatic int unsigned coord_phase(int i, int unsigned pos);
    return (frame_phase[i] + pos * phase_field(step_cfg, i)) & PHASE_MASK;
  endfunction

  // Colour of one pixel; also advances the frame phases as the block does.
  function automatic result_t predict_pixel(coord_t c);
    result_t     out;
    longint      xsum, ysum;
    int unsigned p5, p5_scaled;
    if (c.restart) begin
      for (int i = 0; i < WAVES; i++) frame_phase[i] = phase_field(start_cfg, i);
    end
    xsum = 0;
    for (int i = 0; i < X_WAVES; i++) begin
      xsum += wave_amp(i) * wave_level(coord_phase(i, c.column));
    end
    p5        = coord_phase(4, c.row);
    p5_scaled = ((p5 * MUL_NUM) / MUL_DEN) & PHASE_MASK;
    ysum = wave_amp(3) * wave_level(coord_phase(3, c.row))
         + wave_amp(4) * wave_level(p5 + QUARTER)
         + wave_amp(4) * wave_level(p5_scaled + QUARTER);
    out.colour     = toward_zero_byte(xsum) + toward_zero_byte(ysum);
    out.frame_last = c.frame_end;
    if (c.frame_end) begin
      for (int i = 0; i < WAVES; i++) begin
        frame_phase[i] = (frame_phase[i] + phase_field(speed_cfg, i)) & PHASE_MASK;
      end
    end
    return out;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall and the checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic report_mismatch(string what, int want, int got);
    mismatch_count++;
    if (mismatch_count <= REPORT_CAP) begin
      $display("mismatch: %s expected %0d got %0d", what, want, got);
    end
  endtask

  // Compare every accepted result with the oldest pending colour.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected result, colour", -1, result.colour);
      end else begin
        want = pending_pixels.pop_front();
        if (want.colour !== result.colour) begin
          report_mismatch("colour", want.colour, result.colour);
        end
        if (want.frame_last !== result.frame_last) begin
          report_mismatch("frame_last", want.frame_last, result.frame_last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Coord side and configuration port
  // ---------------------------------------------------------------------------

  // Offer one coord transaction, idle at random first, and predict on acceptance.
  task automatic send_coord(coord_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      coord_valid <= 1'b0;
      @(posedge clk);
    end
    coord_valid <= 1'b1;
    coord       <= c;
    do @(posedge clk); while (coord_stall);
    pending_pixels.push_back(predict_pixel(c));
    items_sent++;
  endtask

  function automatic coord_t make_coord(int col, int row, bit restart, bit frame_end);
    coord_t c;
    c.column    = COORD_W'(col);
    c.row       = COORD_W'(row);
    c.restart   = restart;
    c.frame_end = frame_end;
    return c;
  endfunction

  // Drop valid, let every pending colour arrive, then let the pipeline settle.
  task automatic wait_idle();
    coord_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the data at the
  // edge where the access completes.
  task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx) << CFG_ADDR_LSB;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_AMPLITUDES:    amp_cfg   = value[AMPS_W-1:0];
      REG_SPATIAL_STEPS: step_cfg  = value[FIELDS_W-1:0];
      REG_FRAME_SPEEDS:  speed_cfg = value[FIELDS_W-1:0];
      REG_START_PHASES:  start_cfg = value[FIELDS_W-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_all(logic [AMPS_W-1:0] amps, logic [FIELDS_W-1:0] steps,
                             logic [FIELDS_W-1:0] speeds, logic [FIELDS_W-1:0] starts);
    wait_idle();
    cfg_write(REG_AMPLITUDES,    CFG_DATA_W'(amps));
    cfg_write(REG_SPATIAL_STEPS, CFG_DATA_W'(steps));
    cfg_write(REG_FRAME_SPEEDS,  CFG_DATA_W'(speeds));
    cfg_write(REG_START_PHASES,  CFG_DATA_W'(starts));
  endtask

  // Random register value; all-zero and all-one show up now and then.
  function automatic logic [FIELDS_W-1:0] random_bits(int width);
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(7))
      0:       v = '0;
      1:       v = '1;
      default: ;
    endcase
    return FIELDS_W'(v & ((64'd1 << width) - 1));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // With every register at its reset value all waves vanish: colour 0.
  task automatic test_reset_defaults();
    send_coord(make_coord(0, 0, 1'b0, 1'b0));
    send_coord(make_coord(319, 479, 1'b1, 1'b0));
    send_coord(make_coord(511, 511, 1'b0, 1'b1));
    send_coord(make_coord(170, 85, 1'b1, 1'b1));
  endtask

  // Largest amplitudes and phase fields, then a mixed set; coordinates at the
  // edges of the raster, past them, and at the top of the field width.
  task automatic test_field_extremes();
    program_all('1, '1, '1, '1);
    send_coord(make_coord(0, 0, 1'b1, 1'b0));
    send_coord(make_coord(319, 479, 1'b0, 1'b0));
    send_coord(make_coord(320, 480, 1'b0, 1'b0));
    send_coord(make_coord(511, 511, 1'b0, 1'b0));
    send_coord(make_coord(511, 0, 1'b0, 1'b0));
    send_coord(make_coord(0, 511, 1'b0, 1'b1));
    send_coord(make_coord(341, 170, 1'b0, 1'b0));
    program_all({8'd255, 8'd0, 8'd255, 8'd0, 8'd255}, 60'h001_400_800_C00_FFF,
                60'h3FF_001_800_7FF_C00, 60'h800_C00_400_001_FFF);
    send_coord(make_coord(1, 1, 1'b1, 1'b0));
    send_coord(make_coord(256, 256, 1'b0, 1'b0));
    send_coord(make_coord(255, 255, 1'b0, 1'b1));
    send_coord(make_coord(100, 200, 1'b0, 1'b0));
  endtask

  // Restart loads before the colour, frame_end advances after it; both on
  // one item apply in that order.
  task automatic test_restart_and_frame_end();
    program_all(AMPS_W'({$urandom, $urandom}), random_bits(FIELDS_W),
                60'hFFF_123_801_400_7FF, 60'h456_789_ABC_DEF_012);
    send_coord(make_coord(10, 20, 1'b1, 1'b1));
    send_coord(make_coord(10, 20, 1'b0, 1'b1));
    send_coord(make_coord(10, 20, 1'b0, 1'b0));
    send_coord(make_coord(10, 20, 1'b1, 1'b0));
    send_coord(make_coord(10, 20, 1'b1, 1'b1));
    send_coord(make_coord(10, 20, 1'b0, 1'b0));
  endtask

  // Mostly small raster frames with random placement, some without their
  // frame_end, the rest random noise items.
  task automatic test_random_rasters(int send_pct, int recv_pct, int configs, int per_config);
    int w, h, c0, r0, goal;
    bit restart_first, close_frame;
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    for (int k = 0; k < configs; k++) begin
      program_all(AMPS_W'(random_bits(AMPS_W)), random_bits(FIELDS_W),
                  random_bits(FIELDS_W), random_bits(FIELDS_W));
      goal = items_sent + per_config;
      while (items_sent < goal) begin
        if ($urandom_range(9) < 7) begin
          w  = $urandom_range(1, 8);
          h  = $urandom_range(1, 5);
          c0 = $urandom_range(0, 512 - w);
          r0 = $urandom_range(0, 512 - h);
          restart_first = ($urandom_range(1) != 0);
          close_frame   = ($urandom_range(4) != 0);
          for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
              send_coord(make_coord(c0 + c, r0 + r, restart_first && r == 0 && c == 0,
                                    close_frame && r == h - 1 && c == w - 1));
            end
          end
        end else begin
          send_coord(make_coord($urandom_range(511), $urandom_range(511),
                                $urandom_range(9) == 0, $urandom_range(9) == 0));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    for (int i = 0; i < WAVES; i++) frame_phase[i] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 20;
    stall_pct     = 53;
    test_reset_defaults();
    test_field_extremes();
    test_restart_and_frame_end();

    test_random_rasters(20, 53, 3, 120);
    test_random_rasters(53, 20, 3, 120);
    test_random_rasters(0, 0, 3, 120);

    wait_idle();
    repeat (PIPE_DEPTH) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

FILE: plasma_pixel_generator.f
+incdir+sv
sv/ppg_pkg.sv
sv/plasma_pixel_generator.sv
dv/testbench.sv
